/* hdl/assert_macros.svh */
// Assertion macros used by the chtp_ctrl RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/chtp_pkg.sv */
// ----------------------------------------------------------------------------
// chtp_pkg
// Types and constants of the chained hash table with an entry pool.
// ----------------------------------------------------------------------------
package chtp_pkg;
   localparam int TABLE_SIZE = 1024;
   localparam int IW = $clog2(TABLE_SIZE);
   localparam int PW = IW + 1;
   localparam logic [PW-1:0] NIL = PW'(TABLE_SIZE);
   localparam logic [PW-1:0] LIMIT_RESET = PW'(819);

   // Byte address of the live_limit register.
   localparam logic [1:0] ADDR_LIMIT = 2'd0;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_AUTO = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;
   localparam logic [1:0] MODE_DELETE = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request word
      logic clear_step;  // init sweep write at clear_addr
      logic rd_head;     // read bucket head
      logic rd_entry;    // read entry at cursor
      logic advance;     // prev <= cur
      logic do_insert;   // write the new entry
      logic do_unlink;   // unlink the cursor entry
      logic set_miss;    // result is a miss
      logic set_full;    // result is a refused insert
      logic set_found;   // search hit
      logic [IW-1:0] clear_addr;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [1:0] mode;
      logic can_insert;
      logic table_empty;
      logic cur_nil;
      logic key_match;
   } stat_type;
endpackage

/* hdl/chtp_ctrl.sv */
// ----------------------------------------------------------------------------
// chtp_ctrl
// Sequencer: reset sweep, request intake, chain walk and result handoff.
// ----------------------------------------------------------------------------
module chtp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  chtp_pkg::stat_type stat,
   output chtp_pkg::cmd_type  cmd
);
   import chtp_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_HEAD = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic rsp_ff, rsp_in;
   logic [IW:0] steps_ff, steps_in;
   logic rsp_held;

   assign rsp_valid = rsp_ff;
   assign rsp_held = rsp_ff && rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_held;

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      rsp_in = rsp_held;
      steps_in = steps_ff;
      cmd = '0;
      cmd.clear_addr = addr_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == IW'(TABLE_SIZE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            steps_in = '0;
            if ((stat.mode == MODE_INSERT || stat.mode == MODE_AUTO) && !stat.can_insert) begin
               cmd.set_full = 1'b1;
               state_in = S_DONE;
            end else if (stat.mode == MODE_SEARCH && stat.table_empty) begin
               cmd.set_miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_head = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (stat.mode == MODE_INSERT || stat.mode == MODE_AUTO) begin
               cmd.do_insert = 1'b1;
               state_in = S_DONE;
            end else if (stat.cur_nil || steps_ff[IW]) begin
               cmd.set_miss = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_entry = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.key_match) begin
               if (stat.mode == MODE_SEARCH) cmd.set_found = 1'b1;
               else cmd.do_unlink = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = S_WAIT;
            end
         end
         S_DONE: begin
            if (!rsp_held) begin
               rsp_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         rsp_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rsp_ff <= rsp_in;
         steps_ff <= steps_in;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_load_idle, clock, reset, cmd.load, state_ff == S_IDLE && !rsp_held, "busy load")
   `ASSERT_NEXT(a_done_word, clock, reset, state_ff == S_DONE && !rsp_held, rsp_ff, "word lost")
   `ASSERT_IMPL(a_clear_blocks, clock, reset, state_ff == S_CLEAR, req_stall, "taken in sweep")
endmodule

/* hdl/chtp_data.sv */
// ----------------------------------------------------------------------------
// chtp_data
// Datapath: bucket head and entry memories, free list, live count and result.
// ----------------------------------------------------------------------------
module chtp_data (
   input  logic              clock,
   input  logic              reset,
   input  chtp_pkg::cmd_type  cmd,
   output chtp_pkg::stat_type stat,
   input  logic [1:0]        req_mode,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   input  logic [chtp_pkg::PW-1:0] live_limit,
   output logic [1:0]        rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [9:0]        rsp_slot,
   output logic [9:0]        rsp_bucket
);
   import chtp_pkg::*;

   logic [PW-1:0] head_mem [TABLE_SIZE];
   logic [PW-1:0] next_mem [TABLE_SIZE];
   logic [31:0] key_mem [TABLE_SIZE];
   logic [31:0] val_mem [TABLE_SIZE];

   logic [1:0] mode_ff;
   logic [31:0] key_ff, val_ff;
   logic [PW-1:0] free_ff, live_ff;
   logic [PW-1:0] cur_ff, prev_ff;
   logic [PW-1:0] head_rd_ff, next_rd_ff;
   logic [31:0] key_rd_ff, val_rd_ff;
   logic head_sel_ff;
   logic [1:0] status_ff;
   logic [31:0] vout_ff;
   logic [IW-1:0] slot_ff;
   logic [PW-1:0] cur_in, free_next_ff;
   logic relink_ff;
   logic [IW-1:0] relink_addr_ff;
   logic [PW-1:0] relink_val_ff;

   logic [IW-1:0] bkt;
   assign bkt = key_ff[IW-1:0];

   // Cursor follows the head read first, then each entry's next pointer.
   assign cur_in = head_sel_ff ? head_rd_ff : next_rd_ff;

   assign stat.mode = mode_ff;
   assign stat.can_insert = (32'(live_ff) + 32'd1 < 32'(live_limit)) && !free_ff[IW];
   assign stat.table_empty = (live_ff == '0);
   assign stat.cur_nil = cur_in[IW];
   assign stat.key_match = (key_rd_ff == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         head_mem[cmd.clear_addr] <= NIL;
         next_mem[cmd.clear_addr] <= PW'(cmd.clear_addr) + 1'b1;
      end else if (cmd.do_insert) begin
         next_mem[free_ff[IW-1:0]] <= head_rd_ff;
         head_mem[bkt] <= free_ff;
         key_mem[free_ff[IW-1:0]] <= key_ff;
         val_mem[free_ff[IW-1:0]] <= (mode_ff == MODE_INSERT) ? val_ff : 32'(free_ff);
      end else if (cmd.do_unlink) begin
         if (prev_ff[IW]) head_mem[bkt] <= next_rd_ff;
         else next_mem[prev_ff[IW-1:0]] <= next_rd_ff;
      end else if (relink_ff) begin
         // The freed slot is linked to the old free list in the cycle after the unlink.
         next_mem[relink_addr_ff] <= relink_val_ff;
      end
      if (cmd.rd_head) head_rd_ff <= head_mem[bkt];
      if (cmd.rd_head) free_next_ff <= next_mem[free_ff[IW-1:0]];
      if (cmd.rd_entry) begin
         next_rd_ff <= next_mem[cur_in[IW-1:0]];
         key_rd_ff <= key_mem[cur_in[IW-1:0]];
         val_rd_ff <= val_mem[cur_in[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (cmd.rd_head) head_sel_ff <= 1'b1;
      if (cmd.rd_entry) begin
         cur_ff <= cur_in;
         head_sel_ff <= 1'b0;
      end
      if (cmd.advance) prev_ff <= cur_ff;
      if (cmd.load) prev_ff <= NIL;
      if (cmd.load) begin
         status_ff <= ST_MISS;
         vout_ff <= '0;
         slot_ff <= '0;
      end
      if (cmd.set_full) status_ff <= ST_FULL;
      if (cmd.set_miss) begin
         status_ff <= ST_MISS;
         vout_ff <= (mode_ff == MODE_SEARCH) ? 32'hFFFF_FFFF : 32'd0;
      end
      if (cmd.set_found) begin
         status_ff <= ST_DONE;
         vout_ff <= val_rd_ff;
      end
      if (cmd.do_insert) begin
         status_ff <= ST_DONE;
         slot_ff <= free_ff[IW-1:0];
      end
      if (cmd.do_unlink) status_ff <= ST_DONE;
      relink_ff <= cmd.do_unlink;
      relink_addr_ff <= cur_ff[IW-1:0];
      relink_val_ff <= free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         live_ff <= '0;
      end else if (cmd.do_insert) begin
         free_ff <= free_next_ff;
         live_ff <= live_ff + 1'b1;
      end else if (cmd.do_unlink) begin
         free_ff <= cur_ff;
         if (live_ff != '0) live_ff <= live_ff - 1'b1;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_slot = 10'(slot_ff);
   assign rsp_bucket = 10'(bkt);
endmodule

/* hdl/chained_hash_table_pool.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_pool
// Integer-key hash table, separate chaining over a pooled entry store.
// ----------------------------------------------------------------------------
// Usage: present mode/key/value with req_valid; the word is taken when
// req_stall is low. One result word follows on the rsp_ channel and is held
// until taken (rsp_stall low). One request is worked at a time.
// A refused insert or a search of an empty table is answered without a memory
// read; an insert or auto-insert reads the bucket head, then writes the entry.
// Search and delete walk the chain from the bucket head, each entry being
// one read of the single-port entry memory and one compare.
// The next word can be taken while rsp_valid is high and not stalled.
// A request waits while a previous result is still stalled.
// After reset the block sweeps the bucket and link memories, holding
// req_stall high; csr writes are taken throughout. live_limit sits
// at csr address 0 and resets to 819.
// ----------------------------------------------------------------------------
module chained_hash_table_pool (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [9:0]        rsp_slot,
   output logic [9:0]        rsp_bucket,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import chtp_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [PW-1:0] limit_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_LIMIT) ? 32'(limit_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (psel && penable && pwrite && paddr == ADDR_LIMIT) limit_ff <= pwdata[PW-1:0];
   end

   chtp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
   );

   chtp_data u_data (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_key(req_key), .req_value(req_value),
      .live_limit(limit_ff), .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_slot(rsp_slot), .rsp_bucket(rsp_bucket)
   );
endmodule

/* sim/tb_chained_hash_table_pool.sv */
// ----------------------------------------------------------------------------
// Testbench for chained_hash_table_pool
// Drives insert, auto-insert, search and delete words at the hash table.
// A behavioral copy of the table predicts every result word. The run starts
// with a table of directed words, then moves on to random words under
// several load limits. The key pool is kept small so that chains grow, keys
// repeat and deletes find their targets.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_chained_hash_table_pool;
   import chtp_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [9:0]  slot;
      logic [9:0]  bucket;
   } result_type;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [31:0] value;
      bit          typed;
      result_type  res;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_mode;
   logic signed [31:0] req_key, req_value;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_value_out;
   logic [9:0] rsp_slot, rsp_bucket;
   logic psel, penable, pwrite, pready;
   logic [1:0] paddr;
   logic [31:0] pwdata, prdata;

   // Behavioral copy of the table.
   logic [10:0] tbl_head [TABLE_SIZE];
   logic [10:0] tbl_next [TABLE_SIZE];
   logic [31:0] tbl_key [TABLE_SIZE];
   logic [31:0] tbl_val [TABLE_SIZE];
   logic [10:0] free_ptr;
   int          live_cnt;
   int          limit_val;

   result_type  pending_q[$];
   row_type     dir_q[$];
   logic [31:0] key_pool[48];
   int          errors = 0;
   int          words_in = 0;
   int          idle_cycles = 0;
   int          hold_cnt = 0;
   bit          held = 0;
   int          stall_kind = 0;
   int          stall_left = 0;

   chained_hash_table_pool uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_slot(rsp_slot), .rsp_bucket(rsp_bucket),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic clear_table();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tbl_head[i] = NIL;
         tbl_next[i] = 11'(i + 1);
         tbl_key[i] = '0;
         tbl_val[i] = '0;
      end
      tbl_next[TABLE_SIZE-1] = NIL;
      free_ptr = '0;
      live_cnt = 0;
      limit_val = 819;
   endtask

   // Works out the result word of one request and updates the table copy.
   task automatic hash_table_op(input logic [1:0] m, input logic [31:0] k,
                                input logic [31:0] v, output result_type r);
      logic [9:0]  b;
      logic [10:0] cur, prev;
      int          steps;
      b = k[9:0];
      r.status = ST_MISS;
      r.value_out = '0;
      r.slot = '0;
      r.bucket = b;
      if (m == MODE_INSERT || m == MODE_AUTO) begin
         if (live_cnt + 1 >= limit_val || free_ptr == NIL) begin
            r.status = ST_FULL;
         end else begin
            cur = free_ptr;
            r.slot = cur[9:0];
            free_ptr = tbl_next[cur];
            tbl_key[cur] = k;
            tbl_val[cur] = (m == MODE_INSERT) ? v : 32'(cur);
            tbl_next[cur] = tbl_head[b];
            tbl_head[b] = cur;
            live_cnt++;
            r.status = ST_DONE;
         end
      end else if (m == MODE_SEARCH) begin
         r.value_out = 32'hFFFF_FFFF;
         if (live_cnt != 0) begin
            cur = tbl_head[b];
            for (steps = 0; cur < NIL && steps < TABLE_SIZE; steps++) begin
               if (tbl_key[cur] == k) begin
                  r.status = ST_DONE;
                  r.value_out = tbl_val[cur];
                  break;
               end
               cur = tbl_next[cur];
            end
         end
      end else begin
         prev = NIL;
         cur = tbl_head[b];
         for (steps = 0; cur < NIL && steps < TABLE_SIZE; steps++) begin
            if (tbl_key[cur] == k) begin
               if (prev < NIL)
                  tbl_next[prev] = tbl_next[cur];
               else
                  tbl_head[b] = tbl_next[cur];
               tbl_next[cur] = free_ptr;
               free_ptr = cur;
               if (live_cnt != 0)
                  live_cnt--;
               r.status = ST_DONE;
               break;
            end
            prev = cur;
            cur = tbl_next[cur];
         end
      end
   endtask

   // Offers one word, waits for it to be taken and queues its result.
   task automatic send_word(input logic [1:0] m, input logic [31:0] k,
                            input logic [31:0] v, input bit typed,
                            input result_type typed_res);
      result_type r;
      req_valid <= 1'b1;
      req_mode <= m;
      req_key <= k;
      req_value <= v;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_in++;
      hash_table_op(m, k, v, r);
      if (typed && r != typed_res) begin
         $display("%0t: table row disagrees with prediction: row %p, predicted %p",
                  $realtime, typed_res, r);
         errors++;
      end
      pending_q.push_back(typed ? typed_res : r);
   endtask

   task automatic write_limit(input int lim);
      // Let the block settle before touching the register.
      while (pending_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_LIMIT;
      pwdata <= 32'(lim);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      limit_val = lim;
   endtask

   task automatic random_phase(input int count);
      int      r, burst, gap;
      logic [1:0]  m;
      logic [31:0] k, v;
      result_type dummy;
      burst = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         m = (r < 35) ? MODE_INSERT : (r < 45) ? MODE_AUTO :
             (r < 72) ? MODE_SEARCH : MODE_DELETE;
         k = ($urandom_range(0, 99) < 15) ? $urandom() : key_pool[$urandom_range(0, 47)];
         v = $urandom();
         dummy = '0;
         send_word(m, k, v, 1'b0, dummy);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 12);
            // Some bursts run straight on with no gap at all.
            if ($urandom_range(0, 3) != 0) begin
               gap = $urandom_range(1, 8);
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Result checking and receiver stall pattern.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               $display("%0t: unexpected result word: expected none, actual status %0d",
                        $realtime, rsp_status);
               errors++;
            end else begin
               want = pending_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, rsp_status);
                  errors++;
               end
               if (rsp_value_out !== want.value_out) begin
                  $display("%0t: value_out expected %h actual %h",
                           $realtime, want.value_out, rsp_value_out);
                  errors++;
               end
               if (rsp_slot !== want.slot) begin
                  $display("%0t: slot expected %0d actual %0d",
                           $realtime, want.slot, rsp_slot);
                  errors++;
               end
               if (rsp_bucket !== want.bucket) begin
                  $display("%0t: bucket expected %0d actual %0d",
                           $realtime, want.bucket, rsp_bucket);
                  errors++;
               end
            end
         end
         // One long hold-off while the sender keeps offering words.
         if (!held && words_in >= 330) begin
            held = 1;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0) begin
               stall_kind = $urandom_range(0, 2);
               stall_left = $urandom_range(10, 60);
            end
            stall_left--;
            case (stall_kind)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_chained_hash_table_pool failed");
         $finish;
      end
   end

   initial begin
      result_type none;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_SEARCH;
      req_key = '0;
      req_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      none = '0;
      clear_table();
      // Eight shared buckets, six keys each, so chains and repeats occur.
      for (int i = 0; i < 48; i++)
         key_pool[i] = ($urandom() << 10) | 32'((i % 8) * 97 + 3);

      dir_q.push_back('{MODE_SEARCH, 32'd5, 32'd0, 1, '{ST_MISS, 32'hFFFF_FFFF, 10'd0, 10'd5}});
      dir_q.push_back('{MODE_DELETE, 32'h3FF, 32'd0, 1, '{ST_MISS, 32'd0, 10'd0, 10'd1023}});
      dir_q.push_back('{MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                        '{ST_DONE, 32'd0, 10'd0, 10'd1023}});
      dir_q.push_back('{MODE_AUTO, 32'h8000_0000, 32'hFFFF_FFFF, 1,
                        '{ST_DONE, 32'd0, 10'd1, 10'd0}});
      dir_q.push_back('{MODE_SEARCH, 32'h7FFF_FFFF, 32'd0, 1,
                        '{ST_DONE, 32'h8000_0000, 10'd0, 10'd1023}});
      dir_q.push_back('{MODE_SEARCH, 32'h8000_0000, 32'd0, 1, '{ST_DONE, 32'd1, 10'd0, 10'd0}});
      dir_q.push_back('{MODE_INSERT, 32'h400, 32'h7FFF_FFFF, 1, '{ST_DONE, 32'd0, 10'd2, 10'd0}});
      dir_q.push_back('{MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 1, '{ST_DONE, 32'd0, 10'd3, 10'd0}});
      dir_q.push_back('{MODE_SEARCH, 32'h0, 32'd0, 1, '{ST_DONE, 32'hFFFF_FFFF, 10'd0, 10'd0}});
      dir_q.push_back('{MODE_INSERT, 32'h0, 32'd55, 1, '{ST_DONE, 32'd0, 10'd4, 10'd0}});
      dir_q.push_back('{MODE_SEARCH, 32'h0, 32'd0, 1, '{ST_DONE, 32'd55, 10'd0, 10'd0}});
      dir_q.push_back('{MODE_DELETE, 32'h0, 32'd0, 1, '{ST_DONE, 32'd0, 10'd0, 10'd0}});
      dir_q.push_back('{MODE_SEARCH, 32'h0, 32'd0, 1, '{ST_DONE, 32'hFFFF_FFFF, 10'd0, 10'd0}});
      dir_q.push_back('{MODE_DELETE, 32'h400, 32'd0, 0, none});
      dir_q.push_back('{MODE_SEARCH, 32'h800, 32'd0, 0, none});
      dir_q.push_back('{MODE_AUTO, 32'hFFFF_FFFF, 32'h1234_5678, 0, none});
      dir_q.push_back('{MODE_DELETE, 32'h8000_0000, 32'd0, 0, none});
      dir_q.push_back('{MODE_DELETE, 32'h8000_0000, 32'd0, 0, none});
      dir_q.push_back('{MODE_SEARCH, 32'h8000_0000, 32'd0, 0, none});
      dir_q.push_back('{MODE_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 0, none});
      dir_q.push_back('{MODE_SEARCH, 32'h1234_5678, 32'd0, 0, none});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_q[i])
         send_word(dir_q[i].mode, dir_q[i].key, dir_q[i].value, dir_q[i].typed, dir_q[i].res);
      req_valid <= 1'b0;

      // A limit of one refuses every insert.
      write_limit(1);
      send_word(MODE_INSERT, 32'h5, 32'd9, 1, '{ST_FULL, 32'd0, 10'd0, 10'd5});
      send_word(MODE_AUTO, 32'hFFFF_FC00, 32'd9, 1, '{ST_FULL, 32'd0, 10'd0, 10'd0});
      random_phase(25);
      req_valid <= 1'b0;
      write_limit(1024);
      random_phase(250);
      req_valid <= 1'b0;
      write_limit(6);
      random_phase(60);
      req_valid <= 1'b0;
      write_limit(819);
      random_phase(195);
      req_valid <= 1'b0;

      while (pending_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("tb_chained_hash_table_pool passed");
      else
         $display("tb_chained_hash_table_pool failed");
      $finish;
   end
endmodule
